>>> sv/mmfd_pkg.sv
// Shared types and constants for the MUSCL minmod flux-difference block.
`default_nettype none

package mmfd_pkg;

    // Field widths of the stream and configuration payloads
    localparam int CELL_W     = 32;
    localparam int INDEX_W    = 16;
    localparam int BETA_W     = 18;
    localparam int INV_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FILL_W     = 3;

    // Window fill levels: three cells only load, the fourth primes the flux
    localparam logic [FILL_W-1:0] WINDOW_CELLS = 3'd3;
    localparam logic [FILL_W-1:0] FILL_PRIMED  = 3'd4;

    // Flux selection
    localparam logic MODE_BURGERS = 1'b0;
    localparam logic MODE_LINEAR  = 1'b1;

    // Register reset values (1.0 in Q16.16)
    localparam logic [CELL_W-1:0] SPEED_RST = 32'h0001_0000;
    localparam logic [BETA_W-1:0] BETA_RST  = 18'h1_0000;
    localparam logic [INV_W-1:0]  INV_RST   = 31'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLUX_MODE = 2'd0,
        CFG_ADV_SPEED = 2'd1,
        CFG_LIM_BETA  = 2'd2,
        CFG_INV_WIDTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              flux_mode;
        logic [CELL_W-1:0] adv_speed;
        logic [BETA_W-1:0] beta;
        logic [INV_W-1:0]  inv_width;
    } t_cfg;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_BDM_L,
        OP_BDP_L,
        OP_BDM_R,
        OP_BDP_R,
        OP_SLOPE,
        OP_STATE,
        OP_SQ_L,
        OP_SQ_R,
        OP_DISS,
        OP_FLUX_B,
        OP_FLUX_LIN,
        OP_SCALE,
        OP_PREV
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       load;
        logic [1:0] slot;
        logic       shift;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> sv/mmfd_cfg_regs.sv
// Configuration register bank of the flux-difference block.
`default_nettype none

module mmfd_cfg_regs
    import mmfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write beat onto one register
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_FLUX_MODE: n_cfg.flux_mode = i_wr_data[0];
                CFG_ADV_SPEED: n_cfg.adv_speed = i_wr_data[CELL_W-1:0];
                CFG_LIM_BETA:  n_cfg.beta      = i_wr_data[BETA_W-1:0];
                CFG_INV_WIDTH: n_cfg.inv_width = i_wr_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flux_mode <= MODE_BURGERS;
            r_cfg.adv_speed <= SPEED_RST;
            r_cfg.beta      <= BETA_RST;
            r_cfg.inv_width <= INV_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/mmfd_datapath.sv
// Window, shared multiplier, limiter, flux and scaling datapath.
`default_nettype none

module mmfd_datapath
    import mmfd_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  t_cfg                   i_cfg,
    input  wire logic [CELL_W-1:0] i_cell,
    output logic [CELL_W-1:0]      o_rhs
);

    // Limited products of beta with a 33-bit difference
    localparam int SLW = (51 - FRAC_BITS > 33) ? 51 - FRAC_BITS : 33;
    // Q products of two 33-bit operands
    localparam int QW  = 64 - FRAC_BITS;
    localparam int RW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic signed [71:0] SAT32_HI = 72'sd2147483647;
    localparam logic signed [71:0] SAT32_LO = -72'sd2147483648;
    localparam logic signed [71:0] SATRW_HI = (72'sd1 <<< (RW - 1)) - 72'sd1;
    localparam logic signed [71:0] SATRW_LO = -SATRW_HI - 72'sd1;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic [32:0] abs33(input logic signed [31:0] x);
        logic signed [32:0] xe;
        xe = sx33(x);
        return (xe < 0) ? 33'(-xe) : 33'(xe);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [71:0] x);
        logic [31:0] res;
        if (x > SAT32_HI) res = 32'h7FFF_FFFF;
        else if (x < SAT32_LO) res = 32'h8000_0000;
        else res = x[31:0];
        return res;
    endfunction

    function automatic logic [31:0] sat_rw(input logic signed [71:0] x);
        logic signed [71:0] clip;
        if (x > SATRW_HI) clip = SATRW_HI;
        else if (x < SATRW_LO) clip = SATRW_LO;
        else clip = x;
        return clip[31:0];
    endfunction

    // Beta-limited slope: minmod at beta 1, superbee at beta 2
    function automatic logic signed [SLW-1:0] lim_slope(
        input logic signed [SLW-1:0] bdm,
        input logic signed [SLW-1:0] bdp,
        input logic signed [SLW-1:0] dm,
        input logic signed [SLW-1:0] dp
    );
        logic signed [SLW-1:0] m1;
        logic signed [SLW-1:0] m2;
        logic signed [SLW-1:0] lim;
        if (dp > 0) begin
            m1  = (bdm < dp) ? bdm : dp;
            m2  = (dm < bdp) ? dm : bdp;
            lim = (m1 > m2) ? m1 : m2;
            if (lim < 0) lim = '0;
        end else begin
            m1  = (bdm > dp) ? bdm : dp;
            m2  = (dm > bdp) ? dm : bdp;
            lim = (m1 < m2) ? m1 : m2;
            if (lim > 0) lim = '0;
        end
        return lim;
    endfunction

    logic signed [31:0]    r_a;
    logic signed [31:0]    r_win [3];
    logic signed [SLW-1:0] r_bdm_l, r_bdp_l, r_bdm_r, r_bdp_r;
    logic signed [SLW-1:0] r_slope_l, r_slope_r;
    logic signed [31:0]    r_ul, r_ur;
    logic signed [QW-1:0]  r_sq_l, r_sq_r, r_diss;
    logic signed [32:0]    r_s, r_du;
    logic signed [31:0]    r_flux, r_prev;
    logic [31:0]           r_rhs;

    logic signed [32:0] w_dm_l, w_dp_l, w_dp_r;
    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod, w_prod_q;
    logic [33:0]        w_abs_sum;
    logic signed [71:0] w_fb_sum;
    logic signed [31:0] w_speed;

    // Window a, b, c, d is r_a, r_win[0], r_win[1], r_win[2]
    assign w_dm_l  = sx33(r_win[0]) - sx33(r_a);
    assign w_dp_l  = sx33(r_win[1]) - sx33(r_win[0]);
    assign w_dp_r  = sx33(r_win[2]) - sx33(r_win[1]);
    assign w_speed = $signed(i_cfg.adv_speed);

    // Select the operands of the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_BDM_L: begin
                w_mul_a = $signed({15'd0, i_cfg.beta});
                w_mul_b = w_dm_l;
            end
            OP_BDP_L: begin
                w_mul_a = $signed({15'd0, i_cfg.beta});
                w_mul_b = w_dp_l;
            end
            OP_BDM_R: begin
                w_mul_a = $signed({15'd0, i_cfg.beta});
                w_mul_b = w_dp_l;
            end
            OP_BDP_R: begin
                w_mul_a = $signed({15'd0, i_cfg.beta});
                w_mul_b = w_dp_r;
            end
            OP_SQ_L: begin
                w_mul_a = sx33(r_ul);
                w_mul_b = sx33(r_ul);
            end
            OP_SQ_R: begin
                w_mul_a = sx33(r_ur);
                w_mul_b = sx33(r_ur);
            end
            OP_DISS: begin
                w_mul_a = r_s;
                w_mul_b = r_du;
            end
            OP_FLUX_LIN: begin
                w_mul_a = sx33(w_speed);
                w_mul_b = (w_speed > 0) ? sx33(r_ul) : sx33(r_ur);
            end
            OP_SCALE: begin
                w_mul_a = sx33(r_flux) - sx33(r_prev);
                w_mul_b = $signed({2'b00, i_cfg.inv_width});
            end
            default: ;
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_prod_q  = w_prod >>> FRAC_BITS;
    assign w_abs_sum = {1'b0, abs33(r_ul)} + {1'b0, abs33(r_ur)};
    assign w_fb_sum  = (72'(r_sq_l >>> 1) + 72'(r_sq_r >>> 1) - 72'(r_diss)) >>> 1;

    // Load or shift the window on an accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[i_cmd.slot] <= $signed(i_cell);
        end else if (i_cmd.shift) begin
            r_a      <= r_win[0];
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= $signed(i_cell);
        end
    end

    // Advance one step of the flux computation
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_BDM_L:    r_bdm_l <= w_prod_q[SLW-1:0];
            OP_BDP_L:    r_bdp_l <= w_prod_q[SLW-1:0];
            OP_BDM_R:    r_bdm_r <= w_prod_q[SLW-1:0];
            OP_BDP_R:    r_bdp_r <= w_prod_q[SLW-1:0];
            OP_SLOPE: begin
                r_slope_l <= lim_slope(r_bdm_l, r_bdp_l, SLW'(w_dm_l), SLW'(w_dp_l));
                r_slope_r <= lim_slope(r_bdm_r, r_bdp_r, SLW'(w_dp_l), SLW'(w_dp_r));
            end
            OP_STATE: begin
                r_ul <= $signed(sat32(72'(r_win[0]) + 72'(r_slope_l >>> 1)));
                r_ur <= $signed(sat32(72'(r_win[1]) - 72'(r_slope_r >>> 1)));
            end
            OP_SQ_L: begin
                r_sq_l <= w_prod_q[QW-1:0];
                r_s    <= $signed(w_abs_sum[33:1]);
                r_du   <= sx33(r_ur) - sx33(r_ul);
            end
            OP_SQ_R:     r_sq_r <= w_prod_q[QW-1:0];
            OP_DISS:     r_diss <= w_prod_q[QW-1:0];
            OP_FLUX_B:   r_flux <= $signed(sat32(w_fb_sum));
            OP_FLUX_LIN: r_flux <= $signed(sat32(72'(w_prod_q)));
            OP_SCALE:    r_rhs  <= sat_rw(72'(w_prod_q));
            default: ;
        endcase
    end

    // Hold the flux of the previous interface
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.op == OP_SCALE || i_cmd.op == OP_PREV) begin
            r_prev <= r_flux;
        end
    end

    assign o_rhs = r_rhs;

endmodule

`default_nettype wire

>>> sv/mmfd_ctrl.sv
// Row framing and step sequencer of the flux-difference block.
`default_nettype none

module mmfd_ctrl
    import mmfd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_first,
    input  wire logic               i_in_last,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [INDEX_W-1:0]      o_out_index,
    output logic                    o_out_done,
    input  wire logic               i_flux_mode,
    output t_dp_cmd                 o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BDM_L,
        S_BDP_L,
        S_BDM_R,
        S_BDP_R,
        S_SLOPE,
        S_STATE,
        S_SQ_L,
        S_SQ_R,
        S_DISS,
        S_FLUX_B,
        S_FLUX_LIN,
        S_SCALE
    } t_state;

    t_state               r_state, n_state;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [INDEX_W-1:0]   r_cnt, n_cnt;
    logic                 r_job_emit, n_job_emit;
    logic                 r_job_last, n_job_last;
    logic [INDEX_W-1:0]   r_job_index, n_job_index;
    logic                 r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]   r_out_index, n_out_index;
    logic                 r_out_done, n_out_done;

    logic                 w_accept;
    logic [FILL_W-1:0]    w_fill_eff;
    logic [INDEX_W-1:0]   w_cnt_eff;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_fill_eff = i_in_first ? '0 : r_fill;
    assign w_cnt_eff  = i_in_first ? '0 : r_cnt;

    // Sequence one cell through the datapath
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_job_emit  = r_job_emit;
        n_job_last  = r_job_last;
        n_job_index = r_job_index;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_index = r_out_index;
        n_out_done  = r_out_done;
        o_cmd.op    = OP_NONE;
        o_cmd.load  = 1'b0;
        o_cmd.slot  = '0;
        o_cmd.shift = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_fill_eff < WINDOW_CELLS) begin
                        o_cmd.load = 1'b1;
                        o_cmd.slot = w_fill_eff[1:0];
                        n_fill     = w_fill_eff + 3'd1;
                        n_cnt      = w_cnt_eff;
                    end else begin
                        o_cmd.shift = 1'b1;
                        n_state     = S_BDM_L;
                        n_job_emit  = (w_fill_eff == FILL_PRIMED);
                        n_job_last  = i_in_last;
                        n_job_index = w_cnt_eff;
                        n_fill      = FILL_PRIMED;
                        n_cnt       = (w_fill_eff == FILL_PRIMED)
                                    ? w_cnt_eff + 16'd1 : w_cnt_eff;
                    end
                    if (i_in_last) begin
                        n_fill = '0;
                        n_cnt  = '0;
                    end
                end
            end
            S_BDM_L: begin
                o_cmd.op = OP_BDM_L;
                n_state  = S_BDP_L;
            end
            S_BDP_L: begin
                o_cmd.op = OP_BDP_L;
                n_state  = S_BDM_R;
            end
            S_BDM_R: begin
                o_cmd.op = OP_BDM_R;
                n_state  = S_BDP_R;
            end
            S_BDP_R: begin
                o_cmd.op = OP_BDP_R;
                n_state  = S_SLOPE;
            end
            S_SLOPE: begin
                o_cmd.op = OP_SLOPE;
                n_state  = S_STATE;
            end
            S_STATE: begin
                o_cmd.op = OP_STATE;
                n_state  = (i_flux_mode == MODE_LINEAR) ? S_FLUX_LIN : S_SQ_L;
            end
            S_SQ_L: begin
                o_cmd.op = OP_SQ_L;
                n_state  = S_SQ_R;
            end
            S_SQ_R: begin
                o_cmd.op = OP_SQ_R;
                n_state  = S_DISS;
            end
            S_DISS: begin
                o_cmd.op = OP_DISS;
                n_state  = S_FLUX_B;
            end
            S_FLUX_B: begin
                o_cmd.op = OP_FLUX_B;
                n_state  = S_SCALE;
            end
            S_FLUX_LIN: begin
                o_cmd.op = OP_FLUX_LIN;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                if (!r_job_emit) begin
                    // Priming cell: keep the flux, give no beat
                    o_cmd.op = OP_PREV;
                    n_state  = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_SCALE;
                    n_out_valid = 1'b1;
                    n_out_index = r_job_index;
                    n_out_done  = r_job_last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_job_emit  <= 1'b0;
            r_job_last  <= 1'b0;
            r_job_index <= '0;
            r_out_valid <= 1'b0;
            r_out_index <= '0;
            r_out_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_job_emit  <= n_job_emit;
            r_job_last  <= n_job_last;
            r_job_index <= n_job_index;
            r_out_valid <= n_out_valid;
            r_out_index <= n_out_index;
            r_out_done  <= n_out_done;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_done  = r_out_done;

    // The result register is only overwritten once its beat has gone
    a_scale_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_SCALE) |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_PRIMED)
        else $error("window fill level out of range");

    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> (r_fill == '0 && r_cnt == '0))
        else $error("row framing not cleared after last cell");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SCALE && $past(r_job_emit)))
        else $error("result raised outside the scaling step");

endmodule

`default_nettype wire

>>> sv/muscl_minmod_flux_difference.sv
// MUSCL flux-difference block: takes one row of Q16.16 cell averages per
// frame (two ghost cells before, two after), one cell per beat, and gives
// one saturated (F_right - F_left) * inv_cell_width beat per interior cell,
// tagged with its index among the row's results and tlast on the last one.
// A row of L beats yields L-4 results. The first three cells of a row only
// load the window. Every later cell runs through one shared 33x33
// multiplier: four limiter products, slope, state, two squares,
// dissipation, flux and scaling in Burgers mode, and the same without the
// squares and dissipation in linear advection mode. A finished result waits
// in an output register, so the next cell is taken while it is still
// pending; only the final scaling step waits for the output to be free.
// Configuration writes must only be made while the block is idle.
`default_nettype none

module muscl_minmod_flux_difference
    import mmfd_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Cell stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,  // [31:0] cell_value
    input  wire logic                  s_axis_tuser,  // [0] row_first
    input  wire logic                  s_axis_tlast,  // row_final
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,  // [31:0] rhs_value, [47:32] cell_index
    output logic                       m_axis_tlast,  // row_done
    // Register writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg               w_cfg;
    t_dp_cmd            w_cmd;
    logic [CELL_W-1:0]  w_rhs;
    logic [INDEX_W-1:0] w_out_index;

    assign o_cfg_ready = 1'b1;

    mmfd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    mmfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_first  (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_index (w_out_index),
        .o_out_done  (m_axis_tlast),
        .i_flux_mode (w_cfg.flux_mode),
        .o_cmd       (w_cmd)
    );

    mmfd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_cfg   (w_cfg),
        .i_cell  (s_axis_tdata),
        .o_rhs   (w_rhs)
    );

    // Pack the result beat
    assign m_axis_tdata = {w_out_index, w_rhs};

endmodule

`default_nettype wire

>>> tb/muscl_minmod_flux_difference_test.sv
// Self-checking testbench for the MUSCL minmod flux-difference block.
`timescale 1ns / 100ps

module muscl_minmod_flux_difference_test;
    import mmfd_pkg::*;

    localparam int          FRAC          = 16;
    localparam int          RANDOM_CELLS  = 1050;
    localparam int          PHASE_CELLS   = 85;
    localparam int          BURST_ROW_LEN = 24;
    localparam int          SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam longint      Q_MAX         = (longint'(1) <<< 31) - 1;
    localparam longint      Q_MIN         = -(longint'(1) <<< 31);

    // One result beat as it appears on the master side
    typedef struct packed {
        logic [31:0] rhs;
        logic [15:0] idx;
        logic        done;
    } t_rhs_beat;

    // One row of the directed table; want_* only counts where fixed is set
    typedef struct packed {
        logic [31:0] value;
        logic        row_start;
        logic        row_stop;
        logic        fixed;
        logic [31:0] want_rhs;
        logic [15:0] want_idx;
        logic        want_done;
    } t_cell_row;

    typedef enum {SHAPE_WIDE, SHAPE_NEAR_ZERO, SHAPE_RAMP, SHAPE_EXTREME, SHAPE_FLAT} t_shape;
    typedef enum {ROW_CLEAN, ROW_SHORT, ROW_NO_START, ROW_NO_END, ROW_NOISY} t_row_kind;

    localparam int DIRECTED_N = 22;
    localparam t_cell_row DIRECTED [DIRECTED_N] = '{
        // flat row straight out of reset, no row start: zero flux difference
        '{32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b0, 1'b1, 32'h0, 16'd0, 1'b0},
        '{32'h0001_0000, 1'b0, 1'b1, 1'b1, 32'h0, 16'd1, 1'b1},
        // short row, begun only by the previous row end: no result
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0},
        // alternating extremes, row left open
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        // new row start cuts the open row
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0000_8000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0003_0000, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 16'd0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // [31:0] cell_value
    logic                  s_axis_tuser;   // [0] row_first
    logic                  s_axis_tlast;   // row_final
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // [31:0] rhs_value, [47:32] cell_index
    logic                  m_axis_tlast;   // row_done
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state and its copy of the registers
    longint            cell_win [3];
    longint            last_flux    = 0;
    logic [FILL_W-1:0] fill_level   = '0;
    logic [15:0]       result_index = '0;
    logic              cfg_mode     = MODE_BURGERS;
    longint            cfg_speed    = longint'($signed(SPEED_RST));
    longint            cfg_beta     = longint'(BETA_RST);
    longint            cfg_inv      = longint'(INV_RST);

    t_rhs_beat   expected_rhs [$];
    t_rhs_beat   want;
    int          mismatches  = 0;
    int          cells_sent  = 0;
    int unsigned cycle_count = 0;
    bit          no_idle     = 1'b0;
    bit          sender_calm = 1'b0;
    bit          sink_calm   = 1'b0;

    muscl_minmod_flux_difference dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint x);
        if (x > Q_MAX) return Q_MAX;
        if (x < Q_MIN) return Q_MIN;
        return x;
    endfunction

    // Q16.16 product, rounded toward minus infinity
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    // Beta-limited slope from the backward and forward differences
    function automatic longint limited_slope(longint dm, longint dp);
        longint bdm;
        longint bdp;
        longint lo;
        longint hi;
        bdm = qmul(cfg_beta, dm);
        bdp = qmul(cfg_beta, dp);
        if (dp > 0) begin
            lo = (bdm < dp) ? bdm : dp;
            hi = (dm < bdp) ? dm : bdp;
            lo = (lo > hi) ? lo : hi;
            return (lo > 0) ? lo : 0;
        end
        lo = (bdm > dp) ? bdm : dp;
        hi = (dm > bdp) ? dm : bdp;
        lo = (lo < hi) ? lo : hi;
        return (lo < 0) ? lo : 0;
    endfunction

    // Flux at the interface between b and c
    function automatic longint interface_flux(longint a, longint b, longint c, longint d);
        longint ul;
        longint ur;
        longint spd;
        longint sum;
        longint f;
        ul = sat32(b + (limited_slope(b - a, c - b) >>> 1));
        ur = sat32(c - (limited_slope(c - b, d - c) >>> 1));
        if (cfg_mode == MODE_BURGERS) begin
            spd = ((ul < 0 ? -ul : ul) + (ur < 0 ? -ur : ur)) >>> 1;
            sum = (qmul(ul, ul) >>> 1) + (qmul(ur, ur) >>> 1) - qmul(spd, ur - ul);
            f   = sum >>> 1;
        end else if (cfg_speed > 0) begin
            f = qmul(cfg_speed, ul);
        end else begin
            f = qmul(cfg_speed, ur);
        end
        return sat32(f);
    endfunction

    // Advance the row predictor by one accepted cell
    function automatic void advance_row(input logic [31:0] value, input logic row_start,
                                        input logic row_stop, output logic has,
                                        output t_rhs_beat beat);
        longint v;
        longint f;
        longint r;
        v    = longint'($signed(value));
        has  = 1'b0;
        beat = '0;
        if (row_start) begin
            fill_level   = '0;
            result_index = '0;
        end
        if (fill_level < WINDOW_CELLS) begin
            cell_win[fill_level[1:0]] = v;
            fill_level++;
        end else begin
            f = interface_flux(cell_win[0], cell_win[1], cell_win[2], v);
            cell_win[0] = cell_win[1];
            cell_win[1] = cell_win[2];
            cell_win[2] = v;
            if (fill_level == WINDOW_CELLS) begin
                fill_level = FILL_PRIMED;
            end else begin
                r         = sat32(qmul(f - last_flux, cfg_inv));
                beat.rhs  = r[31:0];
                beat.idx  = result_index;
                beat.done = row_stop;
                result_index++;
                has = 1'b1;
            end
            last_flux = f;
        end
        if (row_stop) begin
            fill_level   = '0;
            result_index = '0;
        end
    endfunction

    function automatic logic [31:0] draw_cell(t_shape shape, logic [31:0] prev);
        case (shape)
            SHAPE_WIDE:      return $urandom();
            SHAPE_NEAR_ZERO: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            SHAPE_RAMP:      return prev + ($urandom_range(0, 32'h0000_4000) - 32'h0000_2000);
            SHAPE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:         return prev;
        endcase
    endfunction

    // Offer one cell after a random gap, hold until taken, then predict
    task automatic send_cell(logic [31:0] value, logic row_start, logic row_stop,
                             logic fixed, t_rhs_beat typed);
        int unsigned gap;
        logic        has;
        t_rhs_beat   beat;
        if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
        gap = (sender_calm || no_idle) ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= row_start;
        s_axis_tlast  <= row_stop;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_row(value, row_start, row_stop, has, beat);
        if (fixed) begin
            expected_rhs.push_back(typed);
        end else if (has) begin
            expected_rhs.push_back(beat);
        end
        cells_sent++;
    endtask

    task automatic send_row(int len, t_row_kind kind);
        t_shape      shape;
        t_shape      pick;
        logic [31:0] value;
        logic        row_start;
        logic        row_stop;
        value = $urandom();
        shape = t_shape'($urandom_range(0, 4));
        for (int k = 0; k < len; k++) begin
            pick  = ($urandom_range(0, 5) == 0) ? t_shape'($urandom_range(0, 4)) : shape;
            value = draw_cell(pick, value);
            case (kind)
                ROW_NO_START: begin
                    row_start = 1'b0;
                    row_stop  = (k == len - 1);
                end
                ROW_NO_END: begin
                    row_start = (k == 0);
                    row_stop  = 1'b0;
                end
                ROW_NOISY: begin
                    row_start = ($urandom_range(0, 5) == 0);
                    row_stop  = ($urandom_range(0, 5) == 0);
                end
                default: begin
                    row_start = (k == 0);
                    row_stop  = (k == len - 1);
                end
            endcase
            send_cell(value, row_start, row_stop, 1'b0, '0);
        end
    endtask

    // Drop valid, let every result drain, then give the datapath time to go idle
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_rhs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; unused upper bits get junk at times
    task automatic load_config(logic mode, logic [31:0] speed, logic [31:0] beta,
                               logic [31:0] inv);
        t_cfg_idx    idx;
        logic [31:0] word;
        logic [31:0] junk;
        for (int k = 0; k < 4; k++) begin
            idx  = t_cfg_idx'(k);
            junk = ($urandom_range(0, 2) == 0) ? $urandom() : 32'h0;
            case (idx)
                CFG_FLUX_MODE: word = {junk[31:1], mode};
                CFG_ADV_SPEED: word = speed;
                CFG_LIM_BETA:  word = {junk[31:BETA_W], beta[BETA_W-1:0]};
                default:       word = {junk[31:INV_W], inv[INV_W-1:0]};
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= word;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_FLUX_MODE: cfg_mode  = word[0];
                CFG_ADV_SPEED: cfg_speed = longint'($signed(word));
                CFG_LIM_BETA:  cfg_beta  = longint'(word[BETA_W-1:0]);
                default:       cfg_inv   = longint'(word[INV_W-1:0]);
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result sink with random back-pressure
    initial begin : result_sink
        int unsigned stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
            stall = (sink_calm || no_idle) ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rhs.size() == 0) begin
                $error("unexpected result beat: rhs_value %h cell_index %0d",
                       m_axis_tdata[31:0], m_axis_tdata[47:32]);
                mismatches++;
            end else begin
                want = expected_rhs.pop_front();
                if (m_axis_tdata[31:0] !== want.rhs) begin
                    $error("rhs_value: expected %h, got %h", want.rhs, m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[47:32] !== want.idx) begin
                    $error("cell_index: expected %0d, got %0d", want.idx, m_axis_tdata[47:32]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.done) begin
                    $error("row_done: expected %b, got %b", want.done, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("muscl_minmod_flux_difference_test NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_rhs_beat   typed;
        t_row_kind   kind;
        int          len;
        int          roll;
        int          phase;
        int          phase_start;
        logic [31:0] speed;
        logic [31:0] beta;
        logic [31:0] inv;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_FLUX_MODE;
        i_cfg_data    <= '0;
        cell_win      = '{0, 0, 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset configuration
        for (int k = 0; k < DIRECTED_N; k++) begin
            typed.rhs  = DIRECTED[k].want_rhs;
            typed.idx  = DIRECTED[k].want_idx;
            typed.done = DIRECTED[k].want_done;
            send_cell(DIRECTED[k].value, DIRECTED[k].row_start, DIRECTED[k].row_stop,
                      DIRECTED[k].fixed, typed);
        end

        // Random phases, each under its own register setting
        phase = 0;
        while (cells_sent < DIRECTED_N + RANDOM_CELLS) begin
            settle_block();
            case (phase)
                0: load_config(MODE_BURGERS, SPEED_RST, 32'h0002_0000, 32'h0001_0000);
                1: load_config(MODE_LINEAR, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF);
                2: load_config(MODE_LINEAR, 32'h8000_0000, 32'h0003_FFFF, 32'h0000_0001);
                3: load_config(MODE_LINEAR, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
                4: load_config(MODE_BURGERS, 32'hFFFF_0000, 32'h0001_8000, 32'h0000_0000);
                5: load_config(MODE_BURGERS, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF);
                default: begin
                    speed = ($urandom_range(0, 1) == 0) ? $urandom()
                          : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                    beta  = ($urandom_range(0, 7) == 0) ? $urandom()
                          : $urandom_range(32'h0001_0000, 32'h0002_0000);
                    inv   = ($urandom_range(0, 3) == 0) ? $urandom()
                          : $urandom_range(0, 32'h0004_0000);
                    load_config(1'($urandom_range(0, 1)), speed, beta, inv);
                end
            endcase
            phase_start = cells_sent;
            while (cells_sent - phase_start < PHASE_CELLS) begin
                roll = $urandom_range(0, 9);
                case (roll)
                    0:       kind = ROW_SHORT;
                    1:       kind = ROW_NO_START;
                    2:       kind = ROW_NO_END;
                    3:       kind = ROW_NOISY;
                    default: kind = ROW_CLEAN;
                endcase
                case (kind)
                    ROW_SHORT: len = $urandom_range(1, 4);
                    ROW_NOISY: len = $urandom_range(2, 16);
                    default:   len = $urandom_range(5, 24);
                endcase
                send_row(len, kind);
            end
            phase++;
        end

        // One row without idling, cells and results back to back
        settle_block();
        load_config(MODE_LINEAR, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                    32'h0002_0000, $urandom_range(0, 32'h0004_0000));
        no_idle = 1'b1;
        send_row(BURST_ROW_LEN, ROW_CLEAN);
        no_idle = 1'b0;

        settle_block();
        if (mismatches == 0) begin
            $display("muscl_minmod_flux_difference_test OK");
        end else begin
            $display("muscl_minmod_flux_difference_test NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/mmfd_pkg.sv
sv/mmfd_cfg_regs.sv
sv/mmfd_datapath.sv
sv/mmfd_ctrl.sv
sv/muscl_minmod_flux_difference.sv
tb/muscl_minmod_flux_difference_test.sv
